// ===== rtl/core/utf8sc_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sc_pkg
// shared types, constants and the script range classifier for the utf-8
// script classifier
// ----------------------------------------------------------------------------
package utf8sc_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned CountOutBits     = 16;
  localparam int unsigned MaskBits         = 6;
  localparam int unsigned PartBits         = 15;
  localparam int unsigned CodeBits         = 21;

  localparam logic [MaskBits-1:0] MaskCommon = 6'h01;
  localparam logic [MaskBits-1:0] MaskLatin  = 6'h02;
  localparam logic [MaskBits-1:0] MaskHan    = 6'h04;
  localparam logic [MaskBits-1:0] MaskKana   = 6'h08;
  localparam logic [MaskBits-1:0] MaskHangul = 6'h10;
  localparam logic [MaskBits-1:0] MaskOther  = 6'h20;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Min   = 8'hC2;
  localparam logic [7:0] Lead2Max   = 8'hDF;
  localparam logic [7:0] Lead3Min   = 8'hE0;
  localparam logic [7:0] Lead3Max   = 8'hEF;
  localparam logic [7:0] Lead4Min   = 8'hF0;
  localparam logic [7:0] Lead4Max   = 8'hF4;
  localparam logic [1:0] ContTag    = 2'b10;

  localparam logic [1:0] SeqLen2 = 2'd1;
  localparam logic [1:0] SeqLen3 = 2'd2;
  localparam logic [1:0] SeqLen4 = 2'd3;

  localparam logic [CodeBits-1:0] Min3Byte   = 21'h000800;
  localparam logic [CodeBits-1:0] Min4Byte   = 21'h010000;
  localparam logic [CodeBits-1:0] MaxCode    = 21'h10FFFF;
  localparam logic [CodeBits-1:0] SurrLo     = 21'h00D800;
  localparam logic [CodeBits-1:0] SurrHi     = 21'h00DFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic                    invalid;
    logic [CountOutBits-1:0] count;
    logic [MaskBits-1:0]     mask;
  } result_t;

  function automatic logic in_rng(input logic [CodeBits-1:0] c,
                                  input logic [CodeBits-1:0] lo,
                                  input logic [CodeBits-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic [MaskBits-1:0] class_of(input logic [CodeBits-1:0] c);
    logic [MaskBits-1:0] cls;
    if (in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A) ||
        in_rng(c, 21'hC0, 21'h24F)) begin
      cls = MaskLatin;
    end else if (in_rng(c, 21'h3040, 21'h30FF) || in_rng(c, 21'h31F0, 21'h31FF)) begin
      cls = MaskKana;
    end else if (in_rng(c, 21'h3400, 21'h4DBF) || in_rng(c, 21'h4E00, 21'h9FFF) ||
                 in_rng(c, 21'hF900, 21'hFAFF)) begin
      cls = MaskHan;
    end else if (in_rng(c, 21'hAC00, 21'hD7AF) || in_rng(c, 21'h1100, 21'h11FF)) begin
      cls = MaskHangul;
    end else if ((c < 21'h80) || in_rng(c, 21'h2000, 21'h206F) ||
                 in_rng(c, 21'h3000, 21'h303F) || in_rng(c, 21'hFF01, 21'hFF20) ||
                 in_rng(c, 21'hFF3B, 21'hFF40) || in_rng(c, 21'hFF5B, 21'hFF65)) begin
      cls = MaskCommon;
    end else begin
      cls = MaskOther;
    end
    return cls;
  endfunction

endpackage

// ===== rtl/core/utf8sc_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8sc_decoder
// string state and one-byte decode step: validation, code point assembly,
// script classification and saturating count
// ----------------------------------------------------------------------------
module utf8sc_decoder
  import utf8sc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  byte_item_t item_i,
  output result_t    res_o
);

  logic [1:0]            pend_q, pend_d;
  logic [1:0]            len_q, len_d;
  logic [PartBits-1:0]   part_q, part_d;
  logic [MaskBits-1:0]   mask_q, mask_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  err_q, err_d;

  logic [CodeBits-1:0]   cp;
  logic [MaskBits-1:0]   cls;
  logic                  acc;
  logic                  bad;
  logic                  err_fin;
  logic [31:0]           cnt_ext;

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    part_d = part_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    err_d  = err_q;
    acc    = 1'b0;
    bad    = 1'b0;
    cp     = {part_q, item_i.data[5:0]};
    if (!err_q) begin
      if (pend_q == 2'd0) begin
        cp = {13'd0, item_i.data};
        priority if (item_i.data < AsciiLimit) begin
          acc = 1'b1;
        end else if (item_i.data >= Lead2Min && item_i.data <= Lead2Max) begin
          part_d = {10'd0, item_i.data[4:0]};
          len_d  = SeqLen2;
          pend_d = SeqLen2;
        end else if (item_i.data >= Lead3Min && item_i.data <= Lead3Max) begin
          part_d = {11'd0, item_i.data[3:0]};
          len_d  = SeqLen3;
          pend_d = SeqLen3;
        end else if (item_i.data >= Lead4Min && item_i.data <= Lead4Max) begin
          part_d = {12'd0, item_i.data[2:0]};
          len_d  = SeqLen4;
          pend_d = SeqLen4;
        end else begin
          err_d = 1'b1;
        end
      end else if (item_i.data[7:6] != ContTag) begin
        err_d  = 1'b1;
        pend_d = 2'd0;
        len_d  = 2'd0;
        part_d = '0;
      end else begin
        pend_d = pend_q - 2'd1;
        part_d = cp[PartBits-1:0];
        if (pend_q == 2'd1) begin
          part_d = '0;
          len_d  = 2'd0;
          bad = ((len_q == SeqLen3) && ((cp < Min3Byte) || in_rng(cp, SurrLo, SurrHi))) ||
                ((len_q == SeqLen4) && ((cp < Min4Byte) || (cp > MaxCode)));
          if (bad) begin
            err_d = 1'b1;
          end else begin
            acc = 1'b1;
          end
        end
      end
    end
    cls = class_of(cp);
    if (acc) begin
      mask_d = mask_q | cls;
      if (cls != MaskCommon && cnt_q != '1) begin
        cnt_d = cnt_q + COUNT_BITS'(1);
      end
    end
  end

  // cut-off sequence at end of string counts as an error
  assign err_fin = err_d || (pend_d != 2'd0);
  assign cnt_ext = 32'(cnt_d);

  always_comb begin
    if (err_fin) begin
      res_o = '{invalid: 1'b1, count: '0, mask: '0};
    end else begin
      res_o = '{invalid: 1'b0, count: cnt_ext[CountOutBits-1:0], mask: mask_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      len_q  <= '0;
      part_q <= '0;
      mask_q <= '0;
      cnt_q  <= '0;
      err_q  <= 1'b0;
    end else if (valid_i) begin
      if (item_i.last) begin
        pend_q <= '0;
        len_q  <= '0;
        part_q <= '0;
        mask_q <= '0;
        cnt_q  <= '0;
        err_q  <= 1'b0;
      end else begin
        pend_q <= pend_d;
        len_q  <= len_d;
        part_q <= part_d;
        mask_q <= mask_d;
        cnt_q  <= cnt_d;
        err_q  <= err_d;
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && item_i.last |=> pend_q == 2'd0 && err_q == 1'b0 &&
                               mask_q == '0 && cnt_q == '0)
    else $error("string state not cleared after final byte");

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> pend_q == 2'd0 && len_q == 2'd0 && part_q == '0)
    else $error("sequence state left over after error");

  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[MaskBits-1:1] != '0 |-> cnt_q != '0)
    else $error("non-common script seen but count is zero");

endmodule

// ===== rtl/core/utf8_script_classifier_core.sv =====
// ----------------------------------------------------------------------------
// utf8_script_classifier_core
// strict utf-8 decoder that reports the script mask and non-common count of
// each string on its final byte
// ----------------------------------------------------------------------------
// path: a final byte passes the input register and then the result register to reach m_axis
// throughput: one byte per cycle unless a final byte waits on an untaken result, set by the
// state update loop in the decoder between the input register and the result register
// reset: asynchronous, clears the stage valids and all string state
// ----------------------------------------------------------------------------
module utf8_script_classifier_core
  import utf8sc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] text_byte
  input  logic        s_axis_tlast_i,  // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [5:0] script_mask, [21:6] script_count,
                                       // [22] invalid_text, [23] zero
);

  logic       in_valid_q;
  byte_item_t in_q;
  logic       advance;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  assign advance         = in_valid_q && (!in_q.last || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= '{data: s_axis_tdata_i, last: s_axis_tlast_i};
    end
  end

  utf8sc_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(advance),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> out_valid_q && !m_axis_tready_i && in_q.last)
    else $error("input stage stalled without a held result");

  a_invalid_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.invalid |-> out_q.mask == '0 && out_q.count == '0)
    else $error("invalid result carries mask or count");

endmodule
